// ===== hw/rtl/qdg_pkg.sv =====
`default_nettype none
package qdg_pkg;
	localparam int W = 24;
	localparam int FRAC_BITS = 16;
	localparam int LANES = 4;
	localparam int N_W = 49;
	localparam int D_W = 50;
	localparam int PW = 128;
	localparam int NW = 130;
	localparam int QW = W + 1;
	localparam int LAT = 34;
	localparam int MA_W = 64;
	localparam int CH = 32;

	localparam logic [N_W-1:0] ONE_SQ = N_W'(1) << (2 * FRAC_BITS);
	localparam logic [W-1:0] POS_LIM = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] NEG_LIM = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic signed [W-1:0] val_x;
		logic signed [W-1:0] val_y;
		logic signed [W-1:0] val_z;
		logic signed [W-1:0] val_w;
		logic signed [W-1:0] grad_x;
		logic signed [W-1:0] grad_y;
		logic signed [W-1:0] grad_z;
		logic signed [W-1:0] grad_w;
		logic last_in;
	} in_t;

	typedef struct packed {
		logic signed [W-1:0] out_x;
		logic signed [W-1:0] out_y;
		logic signed [W-1:0] out_z;
		logic signed [W-1:0] out_w;
		logic last_out;
	} out_t;

	typedef struct packed {
		logic [W-1:0] vmag;
		logic [W-1:0] gmag;
		logic gneg;
		logic t2neg;
		logic [N_W-1:0] dmag;
	} lane_in_t;
endpackage
`default_nettype wire

// ===== hw/rtl/qdg_mul.sv =====
`default_nettype none
module qdg_mul import qdg_pkg::*; (
	input wire logic clk,
	input wire logic [MA_W-1:0] a,
	input wire logic [PW-1:0] b,
	output logic [PW-1:0] p
);
	localparam int NA = MA_W / CH;
	localparam int NB = PW / CH;

	logic [2*CH-1:0] pp_s1 [0:NA-1][0:NB-1];
	logic [PW-1:0] sum;

	always_ff @(posedge clk) begin
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				pp_s1[i][j] <= a[i*CH +: CH] * b[j*CH +: CH];
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				sum = sum + (PW'(pp_s1[i][j]) << (CH * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		p <= sum;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/qdg_lane.sv =====
`default_nettype none
module qdg_lane import qdg_pkg::*; (
	input wire logic clk,
	input wire lane_in_t li,
	input wire logic [PW-1:0] p_nnp1,
	input wire logic [PW-1:0] s_np1sq,
	output logic signed [W-1:0] res
);
	logic [PW-1:0] vd;
	logic [PW-1:0] t1m;
	logic [W-1:0] gmag_s3, gmag_s4;
	logic gneg_s3, gneg_s4, gneg_s5, gneg_s6;
	logic t2neg_s3, t2neg_s4, t2neg_s5, t2neg_s6;
	logic [PW-1:0] t2_s5, t2_s6, sq_s5, sq_s6;
	logic signed [NW-1:0] t1s, t2s, num;
	logic [NW-1:0] mag;
	logic [NW-1:0] rem_q [0:QW];
	logic [NW-1:0] den_q [0:QW];
	logic [QW-1:0] q_q [0:QW];
	logic neg_q [0:QW];

	qdg_mul u_t2 (
		.clk(clk),
		.a(MA_W'(li.vmag)),
		.b(PW'(li.dmag)),
		.p(vd)
	);

	always_ff @(posedge clk) begin
		gmag_s3 <= li.gmag;
		gmag_s4 <= gmag_s3;
		gneg_s3 <= li.gneg;
		gneg_s4 <= gneg_s3;
		gneg_s5 <= gneg_s4;
		gneg_s6 <= gneg_s5;
		t2neg_s3 <= li.t2neg;
		t2neg_s4 <= t2neg_s3;
		t2neg_s5 <= t2neg_s4;
		t2neg_s6 <= t2neg_s5;
		t2_s5 <= vd;
		t2_s6 <= t2_s5;
		sq_s5 <= s_np1sq;
		sq_s6 <= sq_s5;
	end

	qdg_mul u_t1 (
		.clk(clk),
		.a(MA_W'(gmag_s4)),
		.b(p_nnp1),
		.p(t1m)
	);

	always_comb begin
		t1s = gneg_s6 ? -$signed(NW'(t1m)) : $signed(NW'(t1m));
		t2s = t2neg_s6 ? -$signed(NW'(t2_s6) << (1 + 2 * FRAC_BITS))
			: $signed(NW'(t2_s6) << (1 + 2 * FRAC_BITS));
		num = t1s + t2s;
		mag = num[NW-1] ? NW'(-num) : NW'(num);
	end

	always_ff @(posedge clk) begin
		rem_q[0] <= (mag << 1) + NW'(sq_s6);
		den_q[0] <= NW'(sq_s6) << 1;
		q_q[0] <= '0;
		neg_q[0] <= num[NW-1];
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int B = QW - 1 - k;
		logic [NW-1:0] sh;
		logic ge;
		assign sh = den_q[k] << B;
		assign ge = rem_q[k] >= sh;
		always_ff @(posedge clk) begin
			rem_q[k+1] <= ge ? rem_q[k] - sh : rem_q[k];
			q_q[k+1] <= ge ? (q_q[k] | (QW'(1) << B)) : q_q[k];
			den_q[k+1] <= den_q[k];
			neg_q[k+1] <= neg_q[k];
		end
	end

	always_ff @(posedge clk) begin
		if (neg_q[QW]) begin
			res <= (q_q[QW] > QW'(NEG_LIM)) ? NEG_LIM : -q_q[QW][W-1:0];
		end else begin
			res <= (q_q[QW] > QW'(POS_LIM)) ? POS_LIM : q_q[QW][W-1:0];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/quaternion_decay_gradient.sv =====
// channel   direction  handshake      payload
// request   in         start / busy   req (in_t)
// result    out        done strobe    rsp (out_t)
// one request per cycle; busy stays low, four lanes run side by side
// the path from accept to done runs through the 25-step divider pipeline
// reset clears only the valid pipeline; results in flight are dropped
// the receiver cannot stall, each result shows for one cycle with done
`default_nettype none
module quaternion_decay_gradient import qdg_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire in_t req,
	output logic done,
	output out_t rsp
);
	logic signed [W-1:0] vin [0:LANES-1];
	logic signed [W-1:0] gin [0:LANES-1];
	logic signed [2*W-1:0] vv_s1 [0:LANES-1];
	logic signed [2*W-1:0] vg_s1 [0:LANES-1];
	logic [W-1:0] vmag_s1 [0:LANES-1];
	logic [W-1:0] gmag_s1 [0:LANES-1];
	logic vneg_s1 [0:LANES-1];
	logic gneg_s1 [0:LANES-1];
	logic [W-1:0] vmag_s2 [0:LANES-1];
	logic [W-1:0] gmag_s2 [0:LANES-1];
	logic vneg_s2 [0:LANES-1];
	logic gneg_s2 [0:LANES-1];
	logic [N_W-1:0] n_s2;
	logic signed [D_W-1:0] d_s2;
	logic [N_W-1:0] n_sum, np1, dmag;
	logic signed [D_W-1:0] d_sum;
	logic [PW-1:0] p_nnp1, s_np1sq;
	logic signed [W-1:0] res [0:LANES-1];
	logic [LAT-2:0] vld_q;
	logic [LAT-2:0] last_q;
	logic accept;

	assign busy = 1'b0;
	assign accept = start && !busy;

	assign vin[0] = req.val_x;
	assign vin[1] = req.val_y;
	assign vin[2] = req.val_z;
	assign vin[3] = req.val_w;
	assign gin[0] = req.grad_x;
	assign gin[1] = req.grad_y;
	assign gin[2] = req.grad_z;
	assign gin[3] = req.grad_w;

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			vv_s1[i] <= vin[i] * vin[i];
			vg_s1[i] <= vin[i] * gin[i];
			vmag_s1[i] <= vin[i][W-1] ? W'(-vin[i]) : W'(vin[i]);
			gmag_s1[i] <= gin[i][W-1] ? W'(-gin[i]) : W'(gin[i]);
			vneg_s1[i] <= vin[i][W-1];
			gneg_s1[i] <= gin[i][W-1];
		end
	end

	always_comb begin
		n_sum = '0;
		d_sum = '0;
		for (int i = 0; i < LANES; i++) begin
			n_sum = n_sum + N_W'(unsigned'(vv_s1[i]));
			d_sum = d_sum + D_W'(vg_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		n_s2 <= n_sum;
		d_s2 <= d_sum;
		for (int i = 0; i < LANES; i++) begin
			vmag_s2[i] <= vmag_s1[i];
			gmag_s2[i] <= gmag_s1[i];
			vneg_s2[i] <= vneg_s1[i];
			gneg_s2[i] <= gneg_s1[i];
		end
	end

	assign np1 = n_s2 + ONE_SQ;
	assign dmag = d_s2[D_W-1] ? N_W'(-d_s2) : N_W'(d_s2);

	qdg_mul u_nnp1 (
		.clk(clk),
		.a(MA_W'(n_s2)),
		.b(PW'(np1)),
		.p(p_nnp1)
	);

	qdg_mul u_np1sq (
		.clk(clk),
		.a(MA_W'(np1)),
		.b(PW'(np1)),
		.p(s_np1sq)
	);

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		lane_in_t li;
		assign li.vmag = vmag_s2[i];
		assign li.gmag = gmag_s2[i];
		assign li.gneg = gneg_s2[i];
		assign li.t2neg = vneg_s2[i] ^ d_s2[D_W-1];
		assign li.dmag = dmag;
		qdg_lane u_lane (
			.clk(clk),
			.li(li),
			.p_nnp1(p_nnp1),
			.s_np1sq(s_np1sq),
			.res(res[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			done <= 1'b0;
		end else begin
			vld_q <= {vld_q[LAT-3:0], accept};
			done <= vld_q[LAT-2];
		end
	end

	always_ff @(posedge clk) begin
		last_q <= {last_q[LAT-3:0], req.last_in};
		rsp.out_x <= res[0];
		rsp.out_y <= res[1];
		rsp.out_z <= res[2];
		rsp.out_w <= res[3];
		rsp.last_out <= last_q[LAT-2];
	end

`ifndef SYNTH
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done) else $error("result missing");
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT)) else $error("result without request");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.last_out == $past(req.last_in, LAT)) else $error("last flag mismatch");
`endif
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
	import qdg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_t req;
	logic done;
	out_t rsp;

	quaternion_decay_gradient DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	typedef struct {
		in_t stim;
		logic known;
		out_t want;
	} row_t;

	out_t grad_q[$];
	int errors;
	int checked;
	int saturated;
	int sent;
	row_t rows[$];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [W-1:0] lane_grad(logic signed [W-1:0] v, logic signed [W-1:0] g,
			logic [63:0] n, logic signed [63:0] d);
		logic signed [255:0] np1;
		logic signed [255:0] num;
		logic signed [255:0] den;
		logic signed [255:0] mag;
		logic signed [255:0] q;
		logic neg;
		np1 = 256'(n) + (256'sd1 <<< (2 * FRAC_BITS));
		num = 256'(g) * 256'(n) * np1
			+ ((256'(v) * 256'(d)) <<< (1 + 2 * FRAC_BITS));
		den = np1 * np1;
		neg = num < 0;
		mag = neg ? -num : num;
		q = (2 * mag + den) / (2 * den);
		if (neg) begin
			if (q > 256'sd8388608) q = 256'sd8388608;
			return W'(-q);
		end
		if (q > 256'sd8388607) q = 256'sd8388607;
		return W'(q);
	endfunction

	function automatic out_t decay_grad(in_t r);
		logic signed [W-1:0] v[4];
		logic signed [W-1:0] g[4];
		logic [63:0] n;
		logic signed [63:0] d;
		out_t o;
		v = '{r.val_x, r.val_y, r.val_z, r.val_w};
		g = '{r.grad_x, r.grad_y, r.grad_z, r.grad_w};
		n = 0;
		d = 0;
		for (int i = 0; i < 4; i++) begin
			n += 64'(64'(v[i]) * 64'(v[i]));
			d += 64'(v[i]) * 64'(g[i]);
		end
		o.out_x = lane_grad(v[0], g[0], n, d);
		o.out_y = lane_grad(v[1], g[1], n, d);
		o.out_z = lane_grad(v[2], g[2], n, d);
		o.out_w = lane_grad(v[3], g[3], n, d);
		o.last_out = r.last_in;
		return o;
	endfunction

	function automatic logic [W-1:0] rnd_field(int mode);
		case (mode)
			0: return W'($urandom);
			1: return W'($signed(W'($urandom_range(0, 262143))) - 131072);
			2: return W'($signed(W'($urandom_range(0, 4194303))) - 2097152);
			default: return W'($signed(W'($urandom_range(0, 2047))) - 1024);
		endcase
	endfunction

	task automatic add_row(in_t s, logic k, out_t w);
		row_t r;
		r.stim = s;
		r.known = k;
		r.want = w;
		rows.push_back(r);
	endtask

	task automatic send(in_t s);
		start <= 1'b1;
		req <= s;
		do @(posedge clk); while (busy);
		grad_q.push_back(decay_grad(s));
		sent++;
	endtask

	always @(posedge clk) begin
		if (done) begin
			if (grad_q.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				out_t e;
				e = grad_q.pop_front();
				checked++;
				if (e.out_x == POS_LIM || e.out_x == NEG_LIM) saturated++;
				if (rsp.out_x !== e.out_x) begin
					$error("out_x expected %0d got %0d", e.out_x, rsp.out_x);
					errors++;
				end
				if (rsp.out_y !== e.out_y) begin
					$error("out_y expected %0d got %0d", e.out_y, rsp.out_y);
					errors++;
				end
				if (rsp.out_z !== e.out_z) begin
					$error("out_z expected %0d got %0d", e.out_z, rsp.out_z);
					errors++;
				end
				if (rsp.out_w !== e.out_w) begin
					$error("out_w expected %0d got %0d", e.out_w, rsp.out_w);
					errors++;
				end
				if (rsp.last_out !== e.last_out) begin
					$error("last_out expected %0d got %0d", e.last_out, rsp.last_out);
					errors++;
				end
			end
		end
	end

	initial begin
		in_t s;
		out_t w;
		int mode;
		logic [W-1:0] edges[4];
		errors = 0;
		checked = 0;
		saturated = 0;
		sent = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		edges = '{POS_LIM, NEG_LIM, 24'd65536, 24'hFF0000};

		// zeros, unit value, extremes, sign mixes
		s = '0;
		add_row(s, 1'b1, '0);
		s.last_in = 1'b1;
		w = '0;
		w.last_out = 1'b1;
		add_row(s, 1'b1, w);
		s = '0;
		s.grad_x = 24'd65536;
		w = '0;
		add_row(s, 1'b1, w);
		s = '0;
		s.val_y = 24'd65536;
		add_row(s, 1'b1, '0);
		for (int a = 0; a < 4; a++) begin
			for (int b = 0; b < 4; b++) begin
				s = {edges[a], edges[b], edges[(a + 1) % 4], edges[(b + 2) % 4],
					edges[b], edges[a], edges[(a + 3) % 4], edges[(b + 1) % 4], 1'(a ^ b)};
				add_row(s, 1'b0, '0);
			end
		end
		s = {4{24'd256}};
		s = {s[W*4-1:0], {4{POS_LIM}}, 1'b1};
		add_row(s, 1'b0, '0);
		s = {{4{24'd1}}, {4{NEG_LIM}}, 1'b0};
		add_row(s, 1'b0, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].known && rows[i].want !== decay_grad(rows[i].stim)) begin
				$error("directed row %0d: table and predictor disagree", i);
				errors++;
			end
			send(rows[i].stim);
		end

		for (int k = 0; k < 950; k++) begin
			if (k == 700) begin
				start <= 1'b0;
				while (grad_q.size() != 0) @(posedge clk);
			end else if ((k < 200 || k > 500) && $urandom_range(0, 99) < 7) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			s.val_x = rnd_field(mode);
			s.val_y = rnd_field(mode);
			s.val_z = rnd_field(mode);
			s.val_w = rnd_field(mode);
			s.grad_x = rnd_field($urandom_range(0, 3));
			s.grad_y = rnd_field($urandom_range(0, 3));
			s.grad_z = rnd_field($urandom_range(0, 3));
			s.grad_w = rnd_field($urandom_range(0, 3));
			s.last_in = 1'($urandom);
			send(s);
		end

		start <= 1'b0;
		while (grad_q.size() != 0) @(posedge clk);
		repeat (LAT + 10) @(posedge clk);
		$display("run covered %0d requests, %0d results checked (%0d clipped on x)",
			sent, checked, saturated);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/qdg_pkg.sv
hw/rtl/qdg_mul.sv
hw/rtl/qdg_lane.sv
hw/rtl/quaternion_decay_gradient.sv
dv/tb.sv
